[rtl/core/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed: invariant");

// Condition in one cycle that implies a consequence in the next
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[rtl/core/flpss_pkg.sv]
`timescale 1ns / 1ps

package flpss_pkg;

  // Finger count and field counter
  localparam int unsigned NUM_FINGERS = 5;
  localparam int unsigned POS_W       = 3;
  localparam logic [POS_W-1:0] POS_PAST = 3'd5;

  // Angles
  localparam int unsigned ANGLE_W = 8;
  localparam logic [ANGLE_W-1:0] NEUTRAL_ANGLE   = 8'd90;
  localparam logic [ANGLE_W-1:0] RST_CLOSED      = 8'd0;
  localparam logic [ANGLE_W-1:0] RST_OPEN        = 8'd180;
  localparam logic [ANGLE_W-1:0] RST_STEP        = 8'd5;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSED_ANGLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OPEN_ANGLE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE    = 2'd2;

  // Input actions
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  // Characters
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ONE   = 8'h31;

  // Content of the field being received
  typedef enum logic [1:0] {
    FS_EMPTY = 2'd0,
    FS_ONE   = 2'd1,
    FS_BAD   = 2'd2
  } field_status_t;

  typedef logic [ANGLE_W-1:0] angle_t;

endpackage

[rtl/core/finger_line_parser_servo_slew.sv]
`timescale 1ns / 1ps
// Servo hand line parser with slew-limited finger angles. Serial bytes
// (action 0) build lines of up to five comma-separated fields, thumb first;
// a field is open only when, trimmed of whitespace, it is exactly "1". On
// newline the named fingers take their new flags and all five targets are
// set to the open or the closed angle register as it stands then. Each tick
// (action 1) moves every angle toward its target by at most step_size and
// transfers one result: five angles and a changed mask; bytes give none.
// Every item is handled in the cycle it is accepted, so one item a cycle is
// taken; the result register is the only stall point, and a new item is
// taken whenever it is empty or being drained in the same cycle.
// Configuration writes are always taken and should be made while idle.
`include "assert_macros.svh"

module finger_line_parser_servo_slew (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [flpss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [7:0]                          cfg_data,
  // Input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                action,
  input  logic [7:0]                          byte_value,
  // Result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          thumb_angle,
  output logic [7:0]                          index_angle,
  output logic [7:0]                          middle_angle,
  output logic [7:0]                          ring_angle,
  output logic [7:0]                          pinky_angle,
  output logic [4:0]                          changed_mask
);

  import flpss_pkg::*;

  // Configuration registers
  angle_t shut_deg;
  angle_t open_deg;
  angle_t step_size;

  // Line parser state
  logic [POS_W-1:0]       field_position;
  field_status_t          field_status;
  logic [NUM_FINGERS-1:0] line_flags;
  logic [NUM_FINGERS-1:0] line_written;
  logic [NUM_FINGERS-1:0] finger_flags;

  // Finger angles; current angles double as the result payload
  angle_t target_angle  [NUM_FINGERS];
  angle_t current_angle [NUM_FINGERS];
  logic [NUM_FINGERS-1:0] mask;

  logic [POS_W-1:0]       field_position_next;
  field_status_t          field_status_next;
  logic [NUM_FINGERS-1:0] line_flags_next;
  logic [NUM_FINGERS-1:0] line_written_next;
  logic [NUM_FINGERS-1:0] finger_flags_next;
  logic [NUM_FINGERS-1:0] closed_flags;
  logic [NUM_FINGERS-1:0] closed_written;
  logic [NUM_FINGERS-1:0] field_bit;
  logic                   target_load;

  angle_t                 angle_next [NUM_FINGERS];
  angle_t                 gap        [NUM_FINGERS];
  logic [NUM_FINGERS-1:0] mask_next;

  logic in_xfer;
  logic byte_xfer;
  logic tick_xfer;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign byte_xfer = in_xfer && (action == ACT_BYTE);
  assign tick_xfer = in_xfer && (action == ACT_TICK);

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      shut_deg  <= RST_CLOSED;
      open_deg  <= RST_OPEN;
      step_size <= RST_STEP;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CLOSED_ANGLE: shut_deg  <= cfg_data;
        REG_OPEN_ANGLE:   open_deg  <= cfg_data;
        REG_STEP_SIZE:    step_size <= cfg_data;
        default: ;
      endcase
    end
  end

  // Byte decode: field close on comma or newline, line end on newline
  always_comb begin
    field_position_next = field_position;
    field_status_next   = field_status;
    line_flags_next     = line_flags;
    line_written_next   = line_written;
    finger_flags_next   = finger_flags;
    target_load         = 1'b0;
    field_bit           = NUM_FINGERS'(1) << field_position;
    closed_flags        = line_flags;
    closed_written      = line_written;

    if (field_position < POS_PAST) begin
      closed_written = line_written | field_bit;
      if (field_status == FS_ONE) begin
        closed_flags = line_flags | field_bit;
      end else begin
        closed_flags = line_flags & ~field_bit;
      end
    end

    if (byte_xfer) begin
      case (byte_value) inside
        CH_NL: begin
          finger_flags_next   = (finger_flags & ~closed_written) |
                                (closed_flags & closed_written);
          target_load         = 1'b1;
          field_position_next = '0;
          field_status_next   = FS_EMPTY;
          line_flags_next     = '0;
          line_written_next   = '0;
        end
        CH_COMMA: begin
          line_flags_next   = closed_flags;
          line_written_next = closed_written;
          field_status_next = FS_EMPTY;
          if (field_position < POS_PAST) begin
            field_position_next = field_position + POS_W'(1);
          end
        end
        CH_SPACE, CH_TAB, CH_VT, CH_FF, CH_CR: ;
        default: begin
          if (byte_value == CH_ONE && field_status == FS_EMPTY) begin
            field_status_next = FS_ONE;
          end else begin
            field_status_next = FS_BAD;
          end
        end
      endcase
    end
  end

  // Slew step for each finger
  always_comb begin
    for (int i = 0; i < NUM_FINGERS; i++) begin
      angle_next[i] = current_angle[i];
      gap[i]        = '0;
      if (target_angle[i] > current_angle[i]) begin
        gap[i]        = target_angle[i] - current_angle[i];
        angle_next[i] = current_angle[i] + ((gap[i] < step_size) ? gap[i] : step_size);
      end else if (current_angle[i] > target_angle[i]) begin
        gap[i]        = current_angle[i] - target_angle[i];
        angle_next[i] = current_angle[i] - ((gap[i] < step_size) ? gap[i] : step_size);
      end
      mask_next[i] = (angle_next[i] != current_angle[i]);
    end
  end

  // Parser and angle registers
  always_ff @(posedge clk) begin
    if (rst) begin
      field_position <= '0;
      field_status   <= FS_EMPTY;
      line_flags     <= '0;
      line_written   <= '0;
      finger_flags   <= '0;
      for (int i = 0; i < NUM_FINGERS; i++) begin
        target_angle[i]  <= NEUTRAL_ANGLE;
        current_angle[i] <= NEUTRAL_ANGLE;
      end
    end else begin
      field_position <= field_position_next;
      field_status   <= field_status_next;
      line_flags     <= line_flags_next;
      line_written   <= line_written_next;
      finger_flags   <= finger_flags_next;
      for (int i = 0; i < NUM_FINGERS; i++) begin
        if (target_load) begin
          target_angle[i] <= finger_flags_next[i] ? open_deg : shut_deg;
        end
        if (tick_xfer) begin
          current_angle[i] <= angle_next[i];
        end
      end
    end
  end

  // Result register: valid flag and changed mask
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      mask      <= '0;
    end else begin
      if (tick_xfer) begin
        out_valid <= 1'b1;
        mask      <= mask_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign thumb_angle  = current_angle[0];
  assign index_angle  = current_angle[1];
  assign middle_angle = current_angle[2];
  assign ring_angle   = current_angle[3];
  assign pinky_angle  = current_angle[4];
  assign changed_mask = mask;

  // Checks
  `ASSERT_ALWAYS(a_pos_range, field_position <= POS_PAST)
  `ASSERT_NEXT(a_tick_gives_result, tick_xfer, out_valid)
  `ASSERT_NEXT(a_byte_no_result, byte_xfer && !out_valid, !out_valid)
  `ASSERT_NEXT(a_angles_hold_stall, out_valid && !out_ready,
               $stable(mask) && $stable(current_angle[0]) && $stable(current_angle[4]))

endmodule
